// ===== rtl/slx_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell lexer package
// Shared types, constants and helper functions for the shell command line
// lexer: character classes, token kinds, lexer modes and queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

package slx_pkg;

   // Line limit and field widths
   localparam int MAX_LINE = 4096;
   localparam int POS_W    = 13;
   localparam int START_W  = 12;
   localparam int LEN_W    = 13;

   // Queue depths (powers of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_DEPTH   = 4;
   localparam int RPTR_W      = $clog2(RSP_DEPTH);
   localparam int RCNT_W      = $clog2(RSP_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_PIPE  = 8'h7C;

   typedef enum logic [2:0] {
      CLS_END,
      CLS_BLANK,
      CLS_SOLO,
      CLS_PAIR,
      CLS_QUOTE,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [3:0] {
      KIND_WORD    = 4'd0,
      KIND_OPEN    = 4'd1,
      KIND_CLOSE   = 4'd2,
      KIND_OR      = 4'd3,
      KIND_PIPE    = 4'd4,
      KIND_TRUNC   = 4'd5,
      KIND_INPUT   = 4'd6,
      KIND_HEREDOC = 4'd7,
      KIND_APPEND  = 4'd8,
      KIND_AND     = 4'd9,
      KIND_EQUAL   = 4'd10,
      KIND_LINEEND = 4'd11
   } tok_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_META,
      MODE_WORD,
      MODE_QUOTE
   } lex_mode_type;

   // One classified character in flight from front to back
   typedef struct packed {
      logic [7:0]       ch;
      char_class_type   cls;
      logic [POS_W-1:0] pos;
   } q_entry_type;

   // One result item
   typedef struct packed {
      tok_kind_type       kind;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      logic               done;
   } result_type;

   function automatic tok_kind_type single_kind(input logic [7:0] c);
      tok_kind_type k;
      case (c)
         CH_LPAR: k = KIND_OPEN;
         CH_RPAR: k = KIND_CLOSE;
         CH_PIPE: k = KIND_PIPE;
         CH_GT:   k = KIND_TRUNC;
         CH_LT:   k = KIND_INPUT;
         CH_EQ:   k = KIND_EQUAL;
         default: k = KIND_WORD;  // lone ampersand
      endcase
      return k;
   endfunction

   function automatic tok_kind_type pair_kind(input logic [7:0] c);
      tok_kind_type k;
      case (c)
         CH_PIPE: k = KIND_OR;
         CH_LT:   k = KIND_HEREDOC;
         CH_GT:   k = KIND_APPEND;
         default: k = KIND_AND;
      endcase
      return k;
   endfunction

   // Start offsets saturate one below the line limit
   function automatic logic [START_W-1:0] clamp_start(input logic [POS_W-1:0] p);
      logic [START_W-1:0] s;
      if (p >= POS_W'(MAX_LINE - 1)) begin
         s = START_W'(MAX_LINE - 1);
      end else begin
         s = p[START_W-1:0];
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/slx_front.sv =====
// ----------------------------------------------------------------------------
// Shell lexer front end
// Accepts characters, classifies each one and tags it with its saturating
// offset in the line, then hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_front
   import slx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        q_full,
   output logic             q_push,
   output q_entry_type      q_data
);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   char_class_type   cls;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Character classification
   always_comb begin
      if (req_ch == CH_NUL) begin
         cls = CLS_END;
      end else if (req_ch inside {[CH_TAB:CH_CR], CH_SPACE}) begin
         cls = CLS_BLANK;
      end else if (req_ch inside {CH_LPAR, CH_RPAR, CH_EQ}) begin
         cls = CLS_SOLO;
      end else if (req_ch inside {CH_PIPE, CH_AMP, CH_GT, CH_LT}) begin
         cls = CLS_PAIR;
      end else if (req_ch inside {CH_SQ, CH_DQ}) begin
         cls = CLS_QUOTE;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign q_data = '{ch: req_ch, cls: cls, pos: pos_ff};

   // Line offset: saturates at the limit, restarts after the line end
   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (cls == CLS_END) begin
            pos_in = '0;
         end else if (pos_ff < POS_W'(MAX_LINE)) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/slx_queue.sv =====
// ----------------------------------------------------------------------------
// Shell lexer queue
// Short FIFO of classified characters between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_queue
   import slx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire q_entry_type push_data,
   input  wire logic        pop,
   output logic             full,
   output logic             not_empty,
   output q_entry_type      head
);

   q_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff;
   logic [QCNT_W-1:0]  cnt_in;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/slx_back.sv =====
// ----------------------------------------------------------------------------
// Shell lexer back end
// Runs the token state machine on classified characters and writes up to two
// results per character into a small result buffer that feeds the rsp port.
// ----------------------------------------------------------------------------
`default_nettype none

module slx_back
   import slx_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_not_empty,
   input  wire q_entry_type        q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_tok_kind,
   output logic [START_W-1:0]      rsp_tok_start,
   output logic [LEN_W-1:0]        rsp_tok_len,
   output logic                    rsp_line_done
);

   lex_mode_type        mode_ff, mode_in;
   logic [7:0]          held_ff, held_in;
   logic [7:0]          quote_ff, quote_in;
   logic [START_W-1:0]  begin_ff, begin_in;

   result_type          res0, res1, idle_res;
   logic [1:0]          nres;
   logic                idle_path;
   logic                idle_emit;
   logic [START_W-1:0]  cs;
   logic [LEN_W-1:0]    wlen;

   result_type          buf_ff [RSP_DEPTH];
   logic [RPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RCNT_W-1:0]   cnt_ff, cnt_in;
   logic                rsp_pop;

   // Take a character only when two result slots are free
   assign q_pop   = q_not_empty && (cnt_ff <= RCNT_W'(RSP_DEPTH - 2));
   assign rsp_pop = rsp_valid && !rsp_stall;

   assign cs   = clamp_start(q_head.pos);
   assign wlen = (q_head.pos > {1'b0, begin_ff}) ?
                 LEN_W'(q_head.pos - {1'b0, begin_ff}) : '0;

   // Token state machine: next state and results
   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      quote_in  = quote_ff;
      begin_in  = begin_ff;
      res0      = '{kind: KIND_WORD, start: begin_ff, len: wlen, done: 1'b0};
      res1      = res0;
      nres      = 2'd0;
      idle_path = 1'b0;
      idle_emit = 1'b0;
      idle_res  = '{kind: KIND_LINEEND, start: cs, len: '0, done: 1'b1};

      if (q_pop) begin
         // Close or extend the open token
         case (mode_ff)
            MODE_META: begin
               nres    = 2'd1;
               held_in = '0;
               if (q_head.ch == held_ff) begin
                  res0    = '{kind: pair_kind(held_ff), start: begin_ff,
                              len: LEN_W'(2), done: 1'b0};
                  mode_in = MODE_IDLE;
               end else begin
                  res0      = '{kind: single_kind(held_ff), start: begin_ff,
                                len: LEN_W'(1), done: 1'b0};
                  idle_path = 1'b1;
               end
            end
            MODE_WORD: begin
               if (q_head.cls inside {CLS_END, CLS_BLANK, CLS_SOLO, CLS_PAIR}) begin
                  nres      = 2'd1;
                  idle_path = 1'b1;
               end else if (q_head.cls == CLS_QUOTE) begin
                  quote_in = q_head.ch;
                  mode_in  = MODE_QUOTE;
               end
            end
            MODE_QUOTE: begin
               if (q_head.cls == CLS_END) begin
                  nres      = 2'd1;
                  idle_path = 1'b1;
               end else if (q_head.ch == quote_ff) begin
                  quote_in = '0;
                  mode_in  = MODE_WORD;
               end
            end
            default: begin
               idle_path = 1'b1;
            end
         endcase

         // Start of a new token, or the line end
         if (idle_path) begin
            case (q_head.cls)
               CLS_END: begin
                  idle_emit = 1'b1;
                  mode_in   = MODE_IDLE;
                  held_in   = '0;
                  quote_in  = '0;
                  begin_in  = '0;
               end
               CLS_BLANK: begin
                  mode_in = MODE_IDLE;
               end
               CLS_SOLO: begin
                  idle_emit = 1'b1;
                  idle_res  = '{kind: single_kind(q_head.ch), start: cs,
                                len: LEN_W'(1), done: 1'b0};
                  mode_in   = MODE_IDLE;
               end
               CLS_PAIR: begin
                  held_in  = q_head.ch;
                  begin_in = cs;
                  mode_in  = MODE_META;
               end
               CLS_QUOTE: begin
                  begin_in = cs;
                  quote_in = q_head.ch;
                  mode_in  = MODE_QUOTE;
               end
               default: begin
                  begin_in = cs;
                  mode_in  = MODE_WORD;
               end
            endcase
         end

         if (idle_emit) begin
            if (nres == 2'd0) begin
               res0 = idle_res;
               nres = 2'd1;
            end else begin
               res1 = idle_res;
               nres = 2'd2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         held_ff  <= '0;
         quote_ff <= '0;
         begin_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         quote_ff <= quote_in;
         begin_ff <= begin_in;
      end
   end

   // Result buffer: up to two writes, one read per cycle
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RPTR_W'(nres);
      rd_ptr_in = rsp_pop ? rd_ptr_ff + RPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + RCNT_W'(nres) - RCNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (nres != 2'd0) begin
         buf_ff[wr_ptr_ff] <= res0;
      end
      if (nres == 2'd2) begin
         buf_ff[wr_ptr_ff + RPTR_W'(1)] <= res1;
      end
   end

   assign rsp_valid     = (cnt_ff != '0);
   assign rsp_tok_kind  = buf_ff[rd_ptr_ff].kind;
   assign rsp_tok_start = buf_ff[rd_ptr_ff].start;
   assign rsp_tok_len   = buf_ff[rd_ptr_ff].len;
   assign rsp_line_done = buf_ff[rd_ptr_ff].done;

endmodule

`default_nettype wire

// ===== rtl/shell_command_line_lexer_top.sv =====
// ----------------------------------------------------------------------------
// Shell command line lexer
// Streaming tokenizer for shell command lines, one character per transfer.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while req_stall is low: the front
// end classifies the character and tags its line offset, a two-entry queue
// registers it and decouples it from the back end, and the back end runs the
// token state machine and writes up to two results into a four-entry result
// buffer. One character per cycle is sustained as long as each character
// yields at most one result and rsp_stall stays low; a character that closes
// one token and emits another (or the line end) yields two results, and the
// rsp port then drains one result per cycle while rsp_stall is low. Each line
// ends with a line-end result with rsp_line_done set; start offsets saturate
// at 4095, one below the line limit of 4096.
`default_nettype none

module shell_command_line_lexer_top
   import slx_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_ch,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_tok_kind,
   output logic [START_W-1:0]      rsp_tok_start,
   output logic [LEN_W-1:0]        rsp_tok_len,
   output logic                    rsp_line_done
);

   logic        q_full;
   logic        q_push;
   logic        q_pop;
   logic        q_not_empty;
   q_entry_type q_data;
   q_entry_type q_head;

   slx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   slx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   slx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tok_kind  (rsp_tok_kind),
      .rsp_tok_start (rsp_tok_start),
      .rsp_tok_len   (rsp_tok_len),
      .rsp_line_done (rsp_line_done)
   );

endmodule

`default_nettype wire
